@@ src/hcd_pkg.sv @@
`default_nettype none

package hcd_pkg;

	// Default width of the chunk size and data counters
	localparam int LENGTH_BITS_DEF = 64;
	// Width of the chunk_size result field
	localparam int CHUNK_LEN_W = 64;

	typedef logic [CHUNK_LEN_W-1:0] chunk_len_t;

	typedef enum logic [3:0] {
		ST_SIZE   = 4'd0,
		ST_EXT    = 4'd1,
		ST_NL1    = 4'd2,
		ST_DATA   = 4'd3,
		ST_LSTART = 4'd4,
		ST_NAME   = 4'd5,
		ST_VALUE  = 4'd6,
		ST_NL2    = 4'd7,
		ST_NL3    = 4'd8
	} parse_state_t;

	typedef enum logic [1:0] {
		STAT_MORE  = 2'd0,
		STAT_DONE  = 2'd1,
		STAT_ERROR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		TC_NONE      = 3'd0,
		TC_SIZE      = 3'd1,
		TC_EXT       = 3'd2,
		TC_DATA      = 3'd3,
		TC_NAME      = 3'd4,
		TC_VALUE     = 3'd5,
		TC_FIELD_END = 3'd6,
		TC_SIZE_END  = 3'd7
	} token_class_t;

	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef struct packed {
		status_t      status;
		token_class_t token_class;
		logic [7:0]   out_byte;
		chunk_len_t   chunk_size;
		logic         last;
	} hcd_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c < 8'd32) || (c == CH_DEL);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_HT);
	endfunction

	// Token characters: printable ASCII minus the separator set
	function automatic logic is_name_byte(input logic [7:0] c);
		logic sep;
		unique case (c)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D,
			CH_SP, CH_HT: sep = 1'b1;
			default:      sep = 1'b0;
		endcase
		return !c[7] && !is_ctl(c) && !sep;
	endfunction

	function automatic hex_digit_t hex_value(input logic [7:0] c);
		hex_digit_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.value = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic hcd_result_t mk_res(input status_t st, input token_class_t tc,
			input logic [7:0] b, input chunk_len_t len);
		hcd_result_t r;
		r.status      = st;
		r.token_class = tc;
		r.out_byte    = b;
		r.chunk_size  = len;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/hcd_in_if.sv @@
`default_nettype none

interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ src/hcd_out_if.sv @@
`default_nettype none

interface hcd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  token_class;
	logic [7:0]  out_byte;
	logic [63:0] chunk_size;
	logic        last;

	modport source (output valid, output status, output token_class, output out_byte,
		output chunk_size, output last, input ready);
	modport sink (input valid, input status, input token_class, input out_byte,
		input chunk_size, input last, output ready);
	modport mon (input valid, input ready, input status, input token_class,
		input out_byte, input chunk_size, input last);
endinterface

`default_nettype wire

@@ src/http_chunked_decoder.sv @@
`default_nettype none

// HTTP chunked body decoder. One body byte enters per stream transaction and
// yields one or two result transactions, each tagged with a token class:
// size digits, extension, data, trailer name, trailer value, trailer field
// end and size line end (which carries the chunk length). Status is more
// until the final CRLF of a chunk (done) or a malformed byte (error); after
// done or error the parser is back in its reset state, ready for the next
// size line. A size that would not fit LENGTH_BITS is flagged as an error.
// Rate: every byte is parsed in the cycle it is accepted and its results
// land in a two-entry result register, so a byte can be taken every cycle
// while the result side keeps up. A byte that yields two results (a trailer
// field end before a new line, or a folded space before a value byte) holds
// off the next byte until its first result is taken. Results are registered:
// the first is on the port in the cycle after the byte is accepted.
module http_chunked_decoder #(
	parameter int LENGTH_BITS = hcd_pkg::LENGTH_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	hcd_in_if.sink     stream,
	hcd_out_if.source  result
);
	import hcd_pkg::*;

	// ---------------------------------------------------------------
	// Parser state
	// ---------------------------------------------------------------
	parse_state_t           state_q, state_d;
	logic [LENGTH_BITS-1:0] length_acc_q, length_acc_d;
	logic [LENGTH_BITS-1:0] data_left_q, data_left_d;
	logic                   name_seen_q, name_seen_d;
	logic                   value_seen_q, value_seen_d;
	logic                   space_pending_q, space_pending_d;

	// Result buffer: res0_q is on the port, res1_q waits behind it
	hcd_result_t res0_q, res1_q;
	logic [1:0]  cnt_q;

	hcd_result_t res0_d, res1_d;
	logic [1:0]  n_d;

	logic        accept, pop;
	logic [7:0]  c;
	hex_digit_t  hx;
	logic        size_room;

	// Per-byte result pieces: an optional leading result (field end or folded
	// space), then either the byte's own result or a final status result.
	logic        pre_v, main_v;
	hcd_result_t pre_r, main_r, fin_r;
	status_t     fin;

	assign c  = stream.in_byte;
	assign hx = hex_value(c);

	// Another digit is allowed only while acc <= (2^L - 16) / 16 = 2^(L-4) - 1,
	// i.e. the top nibble is still clear.
	assign size_room = (length_acc_q[LENGTH_BITS-1 -: 4] == 4'd0);

	assign pop          = result.valid && result.ready;
	assign stream.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && result.ready);
	assign accept       = stream.valid && stream.ready;

	// ---------------------------------------------------------------
	// Next state and results for the byte on the stream port
	// ---------------------------------------------------------------
	always_comb begin
		state_d         = state_q;
		length_acc_d    = length_acc_q;
		data_left_d     = data_left_q;
		name_seen_d     = name_seen_q;
		value_seen_d    = value_seen_q;
		space_pending_d = space_pending_q;
		pre_v           = 1'b0;
		main_v          = 1'b0;
		pre_r           = mk_res(STAT_MORE, TC_NONE, 8'd0, '0);
		main_r          = mk_res(STAT_MORE, TC_NONE, 8'd0, '0);
		fin             = STAT_MORE;

		unique case (state_q)
			ST_SIZE: begin
				if (c == CH_CR) begin
					state_d = ST_NL1;
					main_v  = 1'b1;
				end else if (c == CH_SEMI) begin
					state_d = ST_EXT;
					main_v  = 1'b1;
					main_r  = mk_res(STAT_MORE, TC_EXT, c, '0);
				end else if (size_room && hx.ok) begin
					length_acc_d = {length_acc_q[LENGTH_BITS-5:0], hx.value};
					main_v       = 1'b1;
					main_r       = mk_res(STAT_MORE, TC_SIZE, c, '0);
				end else begin
					fin = STAT_ERROR;
				end
			end
			ST_EXT: begin
				if (c == CH_CR) begin
					state_d = ST_NL1;
					main_v  = 1'b1;
				end else if (is_ctl(c)) begin
					fin = STAT_ERROR;
				end else begin
					main_v = 1'b1;
					main_r = mk_res(STAT_MORE, TC_EXT, c, '0);
				end
			end
			ST_NL1: begin
				if (c == CH_LF) begin
					data_left_d = length_acc_q;
					state_d     = (length_acc_q == '0) ? ST_LSTART : ST_DATA;
					main_v      = 1'b1;
					main_r      = mk_res(STAT_MORE, TC_SIZE_END, c, chunk_len_t'(length_acc_q));
				end else begin
					fin = STAT_ERROR;
				end
			end
			ST_DATA: begin
				if (data_left_q == '0) begin
					if (c == CH_CR) begin
						state_d = ST_NL3;
						main_v  = 1'b1;
					end else begin
						fin = STAT_ERROR;
					end
				end else begin
					data_left_d = data_left_q - LENGTH_BITS'(1);
					main_v      = 1'b1;
					main_r      = mk_res(STAT_MORE, TC_DATA, c, '0);
				end
			end
			ST_LSTART: begin
				if (is_blank(c)) begin
					// continuation line of the current trailer field
					if (!name_seen_q) begin
						fin = STAT_ERROR;
					end else begin
						state_d         = ST_VALUE;
						space_pending_d = value_seen_q;
						main_v          = 1'b1;
					end
				end else begin
					if (name_seen_q) begin
						pre_v           = 1'b1;
						pre_r           = mk_res(STAT_MORE, TC_FIELD_END, 8'd0, '0);
						name_seen_d     = 1'b0;
						value_seen_d    = 1'b0;
						space_pending_d = 1'b0;
					end
					if (c == CH_CR) begin
						state_d = ST_NL3;
						main_v  = 1'b1;
					end else if (!is_name_byte(c)) begin
						fin = STAT_ERROR;
					end else begin
						state_d     = ST_NAME;
						name_seen_d = 1'b1;
						main_v      = 1'b1;
						main_r      = mk_res(STAT_MORE, TC_NAME, c, '0);
					end
				end
			end
			ST_NAME: begin
				if (c == CH_COLON) begin
					state_d = ST_VALUE;
					main_v  = 1'b1;
				end else if (!is_name_byte(c)) begin
					fin = STAT_ERROR;
				end else begin
					name_seen_d = 1'b1;
					main_v      = 1'b1;
					main_r      = mk_res(STAT_MORE, TC_NAME, c, '0);
				end
			end
			ST_VALUE: begin
				if (c == CH_CR) begin
					state_d = ST_NL2;
					main_v  = 1'b1;
				end else if (is_blank(c)) begin
					space_pending_d = value_seen_q;
					main_v          = 1'b1;
				end else if (is_ctl(c)) begin
					fin = STAT_ERROR;
				end else begin
					if (space_pending_q) begin
						pre_v           = 1'b1;
						pre_r           = mk_res(STAT_MORE, TC_VALUE, CH_SP, '0);
						space_pending_d = 1'b0;
					end
					value_seen_d = 1'b1;
					main_v       = 1'b1;
					main_r       = mk_res(STAT_MORE, TC_VALUE, c, '0);
				end
			end
			ST_NL2: begin
				if (c == CH_LF) begin
					state_d = ST_LSTART;
					main_v  = 1'b1;
				end else begin
					fin = STAT_ERROR;
				end
			end
			ST_NL3: begin
				fin = (c == CH_LF) ? STAT_DONE : STAT_ERROR;
			end
			default: begin
				fin = STAT_ERROR;
			end
		endcase

		fin_r = mk_res(fin, TC_NONE, 8'd0, '0);

		// done or error: back to the reset state
		if (fin != STAT_MORE) begin
			state_d         = ST_SIZE;
			length_acc_d    = '0;
			data_left_d     = '0;
			name_seen_d     = 1'b0;
			value_seen_d    = 1'b0;
			space_pending_d = 1'b0;
		end

		// Pack: [pre] then (fin or main); exactly one of main/fin is present
		if (pre_v) begin
			res0_d = pre_r;
			res1_d = (fin != STAT_MORE) ? fin_r : main_r;
			n_d    = 2'd2;
		end else begin
			res0_d = (fin != STAT_MORE) ? fin_r : main_r;
			res1_d = fin_r;
			n_d    = (main_v || (fin != STAT_MORE)) ? 2'd1 : 2'd0;
		end
		if (n_d == 2'd2) begin
			res1_d.last = 1'b1;
		end else begin
			res0_d.last = 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_SIZE;
			length_acc_q    <= '0;
			data_left_q     <= '0;
			name_seen_q     <= 1'b0;
			value_seen_q    <= 1'b0;
			space_pending_q <= 1'b0;
		end else if (accept) begin
			state_q         <= state_d;
			length_acc_q    <= length_acc_d;
			data_left_q     <= data_left_d;
			name_seen_q     <= name_seen_d;
			value_seen_q    <= value_seen_d;
			space_pending_q <= space_pending_d;
		end
	end

	// Fill count of the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= n_d;
		end else if (pop) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	// Result payload; accept only happens when the buffer is empty or drains this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			res0_q <= res0_d;
			res1_q <= res1_d;
		end else if (pop && (cnt_q == 2'd2)) begin
			res0_q <= res1_q;
		end
	end

	assign result.valid       = (cnt_q != 2'd0);
	assign result.status      = res0_q.status;
	assign result.token_class = res0_q.token_class;
	assign result.out_byte    = res0_q.out_byte;
	assign result.chunk_size  = res0_q.chunk_size;
	assign result.last        = res0_q.last;

endmodule

`default_nettype wire

@@ src/hcd_checker.sv @@
`default_nettype none

module hcd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        valid,
	input wire        ready,
	input wire [1:0]  status,
	input wire [2:0]  token_class,
	input wire [7:0]  out_byte,
	input wire [63:0] chunk_size,
	input wire        last
);
	import hcd_pkg::*;

	// second result of a byte is already buffered
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && !last) |=> valid)
		else $error("second result of a transaction missing");

	// done/error closes the byte's results and carries no token
	a_final_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (status != STAT_MORE)) |->
			(last && (token_class == TC_NONE) && (out_byte == 8'd0)))
		else $error("final status result malformed");

	// only the size line end carries a length
	a_length_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (chunk_size != 64'd0)) |->
			(token_class == TC_SIZE_END))
		else $error("chunk length outside size line end");

	// the first of two results is a field end or a folded space, never final
	a_lead_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |->
			((status == STAT_MORE) &&
			 ((token_class == TC_FIELD_END) ||
			  ((token_class == TC_VALUE) && (out_byte == CH_SP)))))
		else $error("unexpected leading result");

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.status      (result.status),
	.token_class (result.token_class),
	.out_byte    (result.out_byte),
	.chunk_size  (result.chunk_size),
	.last        (result.last)
);

`default_nettype wire
